/* sv/rcsw_pkg.sv */
// Shared types and constants for the RC switch command decoder.
package rcsw_pkg;

    localparam int unsigned CHAN_W  = 5;
    localparam int unsigned PWM_W   = 16;
    localparam int unsigned THR_W   = 11;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PWM_W-1:0] PWM_MIN = 16'd1000;
    localparam logic [PWM_W-1:0] PWM_MAX = 16'd2000;

    localparam logic [CMD_W-1:0] CMD_TAKEOFF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LAND    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ESTOP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ARM_CHANNEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_CHANNEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_PWM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd3;

    localparam logic [CHAN_W-1:0] ARM_CHANNEL_RST   = 5'd4;
    localparam logic [CHAN_W-1:0] MODE_CHANNEL_RST  = 5'd5;
    localparam logic [THR_W-1:0]  THRESHOLD_PWM_RST = 11'd1750;
    localparam logic [DEB_W-1:0]  DEBOUNCE_MS_RST   = 16'd2000;

    typedef struct packed {
        logic arm_level;
        logic mode_level;
        logic prev_arm_level;
        logic prev_mode_level;
        logic awaiting_first;
        logic in_holdoff;
    } frame_view_t;

    typedef struct packed {
        logic             fire;
        logic [CMD_W-1:0] command;
    } decision_t;

endpackage

/* sv/rcsw_edge_decide.sv */
// Edge detection and command choice for one complete RC frame.
module rcsw_edge_decide (
    input  rcsw_pkg::frame_view_t view,
    output rcsw_pkg::decision_t   decision
);

    always_comb begin
        decision.fire    = 1'b0;
        decision.command = rcsw_pkg::CMD_TAKEOFF;
        if (view.awaiting_first || view.in_holdoff) begin
            decision.fire = 1'b0;
        end else if (!view.prev_arm_level && view.arm_level && !view.mode_level) begin
            decision.fire    = 1'b1;
            decision.command = rcsw_pkg::CMD_TAKEOFF;
        end else if (view.prev_arm_level && view.arm_level
                     && !view.prev_mode_level && view.mode_level) begin
            decision.fire    = 1'b1;
            decision.command = rcsw_pkg::CMD_LAND;
        end else if (view.prev_arm_level && !view.arm_level) begin
            decision.fire    = 1'b1;
            decision.command = rcsw_pkg::CMD_ESTOP;
        end
    end

endmodule

/* sv/rc_switch_command_decoder_top.sv */
// Top level of the RC switch command decoder: input register, frame logic, result register.
// A command is registered onto m_tdata from the frame-end item held in the input register.
// Throughput: one item per cycle while m_tready is high; a result held by m_tready low
// holds the input register, so s_tready stays low until the result is taken.
// Reset: synchronous on aresetn low; registers return to arm 4, mode 5, threshold 1750,
// debounce 2000, and the decoder waits for a first complete frame to seed its levels.
module rc_switch_command_decoder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rcsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcsw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // channel_index [4:0], channel_pwm [20:5], time_ms [52:21], zero [55:53]
    input  logic [rcsw_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // command [1:0], zero [7:2]
    output logic [rcsw_pkg::M_DATA_W-1:0]     m_tdata
);

    logic [rcsw_pkg::CHAN_W-1:0] arm_channel_reg;
    logic [rcsw_pkg::CHAN_W-1:0] mode_channel_reg;
    logic [rcsw_pkg::THR_W-1:0]  threshold_pwm_reg;
    logic [rcsw_pkg::DEB_W-1:0]  debounce_ms_reg;

    logic                         in_valid_reg;
    logic [rcsw_pkg::CHAN_W-1:0]  in_index_reg;
    logic [rcsw_pkg::PWM_W-1:0]   in_pwm_reg;
    logic                         in_last_reg;
    logic [rcsw_pkg::TIME_W-1:0]  in_time_reg;

    logic arm_now_reg, arm_now_next;
    logic mode_now_reg, mode_now_next;
    logic arm_seen_reg, arm_seen_next;
    logic mode_seen_reg, mode_seen_next;
    logic prev_arm_reg, prev_arm_next;
    logic prev_mode_reg, prev_mode_next;
    logic awaiting_reg, awaiting_next;
    logic action_taken_reg, action_taken_next;
    logic [rcsw_pkg::TIME_W-1:0] last_action_reg, last_action_next;

    logic                        out_valid_reg, out_valid_next;
    logic [rcsw_pkg::CMD_W-1:0]  out_cmd_reg, out_cmd_next;

    logic                         advance;
    logic [rcsw_pkg::PWM_W-1:0]   pwm_clamped;
    logic                         level_hi;
    logic                         arm_hit, mode_hit;
    logic                         arm_cur, mode_cur, arm_seen_cur, mode_seen_cur;
    logic [rcsw_pkg::TIME_W-1:0]  elapsed;
    logic                         frame_ok;
    rcsw_pkg::frame_view_t        view;
    rcsw_pkg::decision_t          decision;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_channel_reg   <= rcsw_pkg::ARM_CHANNEL_RST;
            mode_channel_reg  <= rcsw_pkg::MODE_CHANNEL_RST;
            threshold_pwm_reg <= rcsw_pkg::THRESHOLD_PWM_RST;
            debounce_ms_reg   <= rcsw_pkg::DEBOUNCE_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rcsw_pkg::REG_ARM_CHANNEL:   arm_channel_reg   <= cfg_data[rcsw_pkg::CHAN_W-1:0];
                rcsw_pkg::REG_MODE_CHANNEL:  mode_channel_reg  <= cfg_data[rcsw_pkg::CHAN_W-1:0];
                rcsw_pkg::REG_THRESHOLD_PWM: threshold_pwm_reg <= cfg_data[rcsw_pkg::THR_W-1:0];
                rcsw_pkg::REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data[rcsw_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_index_reg <= s_tdata[4:0];
            in_pwm_reg   <= s_tdata[20:5];
            in_time_reg  <= s_tdata[52:21];
            in_last_reg  <= s_tlast;
        end
    end

    // Level of the sample and channel latches
    always_comb begin
        if (in_pwm_reg < rcsw_pkg::PWM_MIN) begin
            pwm_clamped = rcsw_pkg::PWM_MIN;
        end else if (in_pwm_reg > rcsw_pkg::PWM_MAX) begin
            pwm_clamped = rcsw_pkg::PWM_MAX;
        end else begin
            pwm_clamped = in_pwm_reg;
        end
    end

    assign level_hi      = pwm_clamped[rcsw_pkg::THR_W-1:0] > threshold_pwm_reg;
    assign arm_hit       = in_index_reg == arm_channel_reg;
    assign mode_hit      = in_index_reg == mode_channel_reg;
    assign arm_cur       = arm_hit ? level_hi : arm_now_reg;
    assign mode_cur      = mode_hit ? level_hi : mode_now_reg;
    assign arm_seen_cur  = arm_seen_reg | arm_hit;
    assign mode_seen_cur = mode_seen_reg | mode_hit;
    assign frame_ok      = in_last_reg && arm_seen_cur && mode_seen_cur;
    assign elapsed       = in_time_reg - last_action_reg;

    always_comb begin
        view.arm_level       = arm_cur;
        view.mode_level      = mode_cur;
        view.prev_arm_level  = prev_arm_reg;
        view.prev_mode_level = prev_mode_reg;
        view.awaiting_first  = awaiting_reg;
        view.in_holdoff      = action_taken_reg
                               && (elapsed[rcsw_pkg::TIME_W-1:rcsw_pkg::DEB_W] == '0)
                               && (elapsed[rcsw_pkg::DEB_W-1:0] < debounce_ms_reg);
    end

    rcsw_edge_decide u_decide (
        .view     (view),
        .decision (decision)
    );

    always_comb begin
        arm_now_next      = arm_now_reg;
        mode_now_next     = mode_now_reg;
        arm_seen_next     = arm_seen_reg;
        mode_seen_next    = mode_seen_reg;
        prev_arm_next     = prev_arm_reg;
        prev_mode_next    = prev_mode_reg;
        awaiting_next     = awaiting_reg;
        action_taken_next = action_taken_reg;
        last_action_next  = last_action_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_cmd_next      = out_cmd_reg;
        if (advance) begin
            arm_now_next   = arm_cur;
            mode_now_next  = mode_cur;
            arm_seen_next  = arm_seen_cur && !in_last_reg;
            mode_seen_next = mode_seen_cur && !in_last_reg;
            if (frame_ok) begin
                prev_arm_next  = arm_cur;
                prev_mode_next = mode_cur;
                awaiting_next  = 1'b0;
                if (decision.fire) begin
                    action_taken_next = 1'b1;
                    last_action_next  = in_time_reg;
                    out_valid_next    = 1'b1;
                    out_cmd_next      = decision.command;
                end
            end
        end
    end

    // Frame state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_now_reg      <= 1'b0;
            mode_now_reg     <= 1'b0;
            arm_seen_reg     <= 1'b0;
            mode_seen_reg    <= 1'b0;
            prev_arm_reg     <= 1'b0;
            prev_mode_reg    <= 1'b0;
            awaiting_reg     <= 1'b1;
            action_taken_reg <= 1'b0;
            last_action_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            arm_now_reg      <= arm_now_next;
            mode_now_reg     <= mode_now_next;
            arm_seen_reg     <= arm_seen_next;
            mode_seen_reg    <= mode_seen_next;
            prev_arm_reg     <= prev_arm_next;
            prev_mode_reg    <= prev_mode_next;
            awaiting_reg     <= awaiting_next;
            action_taken_reg <= action_taken_next;
            last_action_reg  <= last_action_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cmd_reg <= out_cmd_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rcsw_pkg::M_DATA_W - rcsw_pkg::CMD_W){1'b0}}, out_cmd_reg};

endmodule

/* test/rc_switch_command_decoder_checker.sv */
// Checker for the RC switch command decoder: tracks the switch levels, predicts commands and compares.
module rc_switch_command_decoder_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rcsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcsw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // channel_index [4:0], channel_pwm [20:5], time_ms [52:21], zero [55:53]
    input  logic [rcsw_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // command [1:0], zero [7:2]
    input  logic [rcsw_pkg::M_DATA_W-1:0]   m_tdata,
    output int                              fault_count,
    output int                              cmds_owed
);

    logic [rcsw_pkg::CHAN_W-1:0] arm_ch;
    logic [rcsw_pkg::CHAN_W-1:0] mode_ch;
    logic [rcsw_pkg::THR_W-1:0]  thr;
    logic [rcsw_pkg::DEB_W-1:0]  deb;
    logic                        arm_hi;
    logic                        mode_hi;
    logic                        arm_seen;
    logic                        mode_seen;
    logic                        arm_prev;
    logic                        mode_prev;
    logic                        seeding;
    logic                        acted;
    logic [rcsw_pkg::TIME_W-1:0] last_cmd_ms;
    logic [rcsw_pkg::CMD_W-1:0]  cmd_owed_q[$];
    logic [rcsw_pkg::CMD_W-1:0]  want_cmd;

    function automatic logic pwm_high(input logic [rcsw_pkg::PWM_W-1:0] pwm);
        logic [rcsw_pkg::PWM_W-1:0] p;
        p = pwm;
        if (p < rcsw_pkg::PWM_MIN) p = rcsw_pkg::PWM_MIN;
        if (p > rcsw_pkg::PWM_MAX) p = rcsw_pkg::PWM_MAX;
        return p > {5'd0, thr};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s: got %0d, want %0d", $realtime, what, got, want);
        fault_count++;
    endtask

    task automatic decode_sample(input logic [rcsw_pkg::CHAN_W-1:0] idx,
                                 input logic [rcsw_pkg::PWM_W-1:0] pwm,
                                 input logic last, input logic [rcsw_pkg::TIME_W-1:0] now);
        logic                        hi;
        logic                        fire;
        logic [rcsw_pkg::CMD_W-1:0]  cmd;
        logic [rcsw_pkg::TIME_W-1:0] since;
        hi    = pwm_high(pwm);
        fire  = 1'b0;
        cmd   = rcsw_pkg::CMD_TAKEOFF;
        since = now - last_cmd_ms;
        if (idx == arm_ch) begin
            arm_hi   = hi;
            arm_seen = 1'b1;
        end
        if (idx == mode_ch) begin
            mode_hi   = hi;
            mode_seen = 1'b1;
        end
        if (!last) return;
        if (!(arm_seen && mode_seen)) begin
            arm_seen  = 1'b0;
            mode_seen = 1'b0;
            return;
        end
        arm_seen  = 1'b0;
        mode_seen = 1'b0;
        if (seeding) begin
            seeding = 1'b0;
        end else if (acted && since < {16'd0, deb}) begin
            // hold-off: levels only
        end else if (!arm_prev && arm_hi && !mode_hi) begin
            fire = 1'b1;
            cmd  = rcsw_pkg::CMD_TAKEOFF;
        end else if (arm_prev && arm_hi && !mode_prev && mode_hi) begin
            fire = 1'b1;
            cmd  = rcsw_pkg::CMD_LAND;
        end else if (arm_prev && !arm_hi) begin
            fire = 1'b1;
            cmd  = rcsw_pkg::CMD_ESTOP;
        end
        arm_prev  = arm_hi;
        mode_prev = mode_hi;
        if (fire) begin
            acted       = 1'b1;
            last_cmd_ms = now;
            cmd_owed_q.push_back(cmd);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            arm_ch      = rcsw_pkg::ARM_CHANNEL_RST;
            mode_ch     = rcsw_pkg::MODE_CHANNEL_RST;
            thr         = rcsw_pkg::THRESHOLD_PWM_RST;
            deb         = rcsw_pkg::DEBOUNCE_MS_RST;
            arm_hi      = 1'b0;
            mode_hi     = 1'b0;
            arm_seen    = 1'b0;
            mode_seen   = 1'b0;
            arm_prev    = 1'b0;
            mode_prev   = 1'b0;
            seeding     = 1'b1;
            acted       = 1'b0;
            last_cmd_ms = '0;
            cmd_owed_q.delete();
            fault_count = 0;
            cmds_owed   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cmd_owed_q.size() == 0) begin
                    report_mismatch("command with none owed",
                                    int'(m_tdata[rcsw_pkg::CMD_W-1:0]), -1);
                end else begin
                    want_cmd = cmd_owed_q.pop_front();
                    if (m_tdata[rcsw_pkg::CMD_W-1:0] !== want_cmd) begin
                        report_mismatch("command", int'(m_tdata[rcsw_pkg::CMD_W-1:0]),
                                        int'(want_cmd));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    rcsw_pkg::REG_ARM_CHANNEL:   arm_ch  = cfg_data[rcsw_pkg::CHAN_W-1:0];
                    rcsw_pkg::REG_MODE_CHANNEL:  mode_ch = cfg_data[rcsw_pkg::CHAN_W-1:0];
                    rcsw_pkg::REG_THRESHOLD_PWM: thr     = cfg_data[rcsw_pkg::THR_W-1:0];
                    rcsw_pkg::REG_DEBOUNCE_MS:   deb     = cfg_data[rcsw_pkg::DEB_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_sample(s_tdata[4:0], s_tdata[20:5], s_tlast, s_tdata[52:21]);
            end
            cmds_owed = cmd_owed_q.size();
        end
    end

endmodule

/* test/rc_switch_command_decoder_top_test.sv */
// Testbench top for the RC switch command decoder: clock, reset, frame stimulus and verdict.
module rc_switch_command_decoder_top_test;

    localparam int CYCLE_LIMIT = 1000000;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [rcsw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rcsw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rcsw_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rcsw_pkg::M_DATA_W-1:0]   m_tdata;
    int                              fault_count;
    int                              cmds_owed;
    int                              cycle_count = 0;
    int                              items_sent = 0;
    int                              phase_items;
    int                              phase;
    int                              r;
    int                              ready_pick;
    bit                              steady = 1'b0;

    logic [rcsw_pkg::CHAN_W-1:0]     arm_cfg  = rcsw_pkg::ARM_CHANNEL_RST;
    logic [rcsw_pkg::CHAN_W-1:0]     mode_cfg = rcsw_pkg::MODE_CHANNEL_RST;
    logic [rcsw_pkg::THR_W-1:0]      thr_cfg  = rcsw_pkg::THRESHOLD_PWM_RST;
    logic [rcsw_pkg::DEB_W-1:0]      deb_cfg  = rcsw_pkg::DEBOUNCE_MS_RST;
    logic [rcsw_pkg::TIME_W-1:0]     now_ms   = '0;

    rc_switch_command_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rc_switch_command_decoder_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fault_count (fault_count),
        .cmds_owed   (cmds_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rc_switch_command_decoder_top_test: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int g;
        if (steady) return 0;
        g = $urandom_range(0, 99);
        if (g < 55) return 0;
        if (g < 88) return $urandom_range(1, 3);
        if (g < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [rcsw_pkg::PWM_W-1:0] level_pwm(input bit want_high);
        logic [rcsw_pkg::PWM_W-1:0] p;
        logic [rcsw_pkg::PWM_W-1:0] c;
        int                         pick;
        for (int tries = 0; tries < 16; tries++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) p = {5'd0, thr_cfg} + 16'($urandom_range(0, 3)) - 16'd1;
            else if (pick < 75) p = 16'($urandom_range(950, 2050));
            else if (pick < 88) p = 16'($urandom_range(0, 999));
            else p = 16'($urandom_range(0, 65535));
            c = p;
            if (c < rcsw_pkg::PWM_MIN) c = rcsw_pkg::PWM_MIN;
            if (c > rcsw_pkg::PWM_MAX) c = rcsw_pkg::PWM_MAX;
            if ((c > {5'd0, thr_cfg}) == want_high) return p;
        end
        return p;
    endfunction

    function automatic logic [rcsw_pkg::TIME_W-1:0] time_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 32'($urandom_range(0, 40));
        if (pick < 75) return {16'd0, deb_cfg} + 32'($urandom_range(0, 100)) - 32'd50;
        if (pick < 92) return {16'd0, deb_cfg} - 32'd1 + 32'($urandom_range(0, 1));
        return 32'($urandom);
    endfunction

    task automatic send_item(input logic [rcsw_pkg::CHAN_W-1:0] idx,
                             input logic [rcsw_pkg::PWM_W-1:0] pwm,
                             input bit last, input logic [rcsw_pkg::TIME_W-1:0] t);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t, pwm, idx};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // flaw: 0 clean, 1 arm channel missing, 2 mode channel missing, 3 arm channel repeated
    task automatic send_frame(input bit arm_lvl, input bit mode_lvl, input int flaw);
        logic [rcsw_pkg::CHAN_W-1:0] ids[$];
        logic [rcsw_pkg::PWM_W-1:0]  pwms[$];
        int                          pos;
        int                          n;
        if (flaw != 1) begin
            ids.push_back(arm_cfg);
            pwms.push_back(level_pwm(arm_lvl));
        end
        if (flaw != 2) begin
            pos = $urandom_range(0, ids.size());
            ids.insert(pos, mode_cfg);
            pwms.insert(pos, level_pwm(mode_lvl));
        end
        if (flaw == 3) begin
            ids.push_front(arm_cfg);
            pwms.push_front(level_pwm(!arm_lvl));
        end
        repeat ($urandom_range(0, 3)) begin
            pos = $urandom_range(0, ids.size());
            ids.insert(pos, 5'($urandom_range(0, 31)));
            pwms.insert(pos, 16'($urandom));
        end
        now_ms = now_ms + time_step();
        n = ids.size();
        for (int k = 0; k < n; k++) begin
            send_item(ids[k], pwms[k], k == n - 1, (k == n - 1) ? now_ms : 32'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (cmds_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rcsw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcsw_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [rcsw_pkg::CHAN_W-1:0] arm,
                               input logic [rcsw_pkg::CHAN_W-1:0] mode,
                               input logic [rcsw_pkg::THR_W-1:0] thr,
                               input logic [rcsw_pkg::DEB_W-1:0] deb);
        arm_cfg  = arm;
        mode_cfg = mode;
        thr_cfg  = thr;
        deb_cfg  = deb;
        write_reg(rcsw_pkg::REG_ARM_CHANNEL, {11'd0, arm});
        write_reg(rcsw_pkg::REG_MODE_CHANNEL, {11'd0, mode});
        write_reg(rcsw_pkg::REG_THRESHOLD_PWM, {5'd0, thr});
        write_reg(rcsw_pkg::REG_DEBOUNCE_MS, deb);
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 40) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end else if (ready_pick < 48) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 200)) @(negedge aclk);
            end else if (ready_pick < 78) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end else if (ready_pick < 96) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(4, 10)) @(negedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 40)) @(negedge aclk);
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = rcsw_pkg::REG_ARM_CHANNEL;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // seed levels: arm low, mode high
        send_item(5'd4, 16'h0000, 1'b0, 32'hFFFF_FFFF);
        send_item(5'd5, 16'hFFFF, 1'b1, 32'd0);
        // takeoff, threshold edge on both channels
        send_item(5'd0, 16'd1751, 1'b0, 32'd0);
        send_item(5'd4, 16'd1751, 1'b0, 32'd0);
        send_item(5'd5, 16'd1750, 1'b1, 32'd10);
        // hold-off: track levels only
        send_item(5'd4, 16'd2000, 1'b0, 32'd0);
        send_item(5'd5, 16'd999, 1'b1, 32'd20);
        // land exactly at the end of the hold-off
        send_item(5'd5, 16'd1999, 1'b0, 32'd0);
        send_item(5'd4, 16'd1900, 1'b1, 32'd2010);
        // drop: mode channel missing
        send_item(5'd4, 16'd1000, 1'b1, 32'd5000);
        // repeated arm channel, last one wins: emergency stop
        send_item(5'd4, 16'd2000, 1'b0, 32'd0);
        send_item(5'd5, 16'd1000, 1'b0, 32'd0);
        send_item(5'd4, 16'd1000, 1'b1, 32'd5000);
        // takeoff near the top of the time range
        send_item(5'd4, 16'd2001, 1'b0, 32'd0);
        send_item(5'd5, 16'd0, 1'b0, 32'd0);
        send_item(5'd31, 16'hFFFF, 1'b1, 32'hFFFF_FFF0);
        // wrapped time still inside the hold-off
        send_item(5'd4, 16'd0, 1'b0, 32'd0);
        send_item(5'd5, 16'd0, 1'b1, 32'h0000_0100);

        phase = 0;
        while (items_sent < 1950) begin
            wait_idle();
            case (phase)
                0: load_config(5'd0, 5'd31, 11'd1000, 16'd0);
                1: load_config(5'd31, 5'd0, 11'd1999, 16'hFFFF);
                2: load_config(5'd7, 5'd7, 11'd1500, 16'd50);
                3: load_config(5'd3, 5'd9, 11'd0, 16'd100);
                4: load_config(5'd12, 5'd2, 11'd2047, 16'd1);
                5: load_config(5'd4, 5'd5, 11'd2000, 16'd10);
                default: load_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                     ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                                                 : 11'($urandom_range(1000, 2000)),
                                     ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 300)));
            endcase
            phase_items = items_sent + $urandom_range(150, 250);
            while (items_sent < phase_items && items_sent < 1950) begin
                if ($urandom_range(0, 31) == 0) steady = !steady;
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_frame($urandom_range(0, 1), $urandom_range(0, 1), 0);
                end else if (r < 90) begin
                    send_frame($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 3));
                end else begin
                    send_item(5'($urandom_range(0, 31)), 16'($urandom),
                              $urandom_range(0, 3) == 0, 32'($urandom));
                end
            end
            phase++;
        end

        wait_idle();
        if (fault_count == 0) begin
            $display("rc_switch_command_decoder_top_test: clean");
        end else begin
            $display("rc_switch_command_decoder_top_test: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/rcsw_pkg.sv
sv/rcsw_edge_decide.sv
sv/rc_switch_command_decoder_top.sv
test/rc_switch_command_decoder_checker.sv
test/rc_switch_command_decoder_top_test.sv
